### hw/rtl/xrr_pkg.sv
// Shared constants and types for the ranged xoshiro256** random generator.
// Holds the splitmix64 and generator constants, request codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xrr_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = WordW / 2;
  localparam int unsigned CntW    = $clog2(WordW);
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned FuncW   = 3;

  localparam logic [WordW-1:0] Golden       = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MixMulFirst  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MixMulSecond = 64'h94D0_49BB_1331_11EB;
  localparam logic [WordW-1:0] DefaultSeedA = 64'd3782560128497;
  localparam logic [WordW-1:0] DefaultSeedB = 64'd178260123457;

  localparam logic [CfgIdxW-1:0] RegSeedFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSeedSecond = 2'd1;

  localparam logic [FuncW-1:0] FuncU64 = 3'd0;
  localparam logic [FuncW-1:0] FuncU32 = 3'd1;
  localparam logic [FuncW-1:0] FuncU16 = 3'd2;
  localparam logic [FuncW-1:0] FuncS64 = 3'd3;
  localparam logic [FuncW-1:0] FuncS32 = 3'd4;
  localparam logic [FuncW-1:0] FuncS16 = 3'd5;

  typedef enum logic [3:0] {
    ST_START,
    ST_SEED_ADD,
    ST_MIX,
    ST_MUL,
    ST_STORE,
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic cfg_ready;
    logic in_ready;
  } ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/xoshiro256ss_ranged_random_top.sv
// Ranged xoshiro256** random generator with splitmix64 seeding.
// One sequencer drives a shared 32x32 multiplier (seeding) and a radix-2
// remainder unit (draws). Depends on xrr_pkg.
//
// Channels: a request (func, limit) on in_valid/in_ready, a result (value,
// div_zero) on out_valid/out_ready, and seed writes on cfg_valid/cfg_ready
// with cfg_index 0 for seed_first and 1 for seed_second.
// A request is taken only while the sequencer is idle. It advances the
// generator, prepares magnitudes in a preparation step, runs 64 restoring
// remainder steps (one bit a cycle) and signs the result in a final step,
// which registers it. A zero limit skips the remainder loop and goes from
// preparation straight to the final step.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver still holds the previous result when a new one is
// ready, the sequencer waits in its final step until the register frees.
// Reset clears both seeds and expands the default seeds into the state:
// four splitmix64 words, with the 64x64 products built from three 32x32
// partial products.
// A seed write reseeds the same way; neither port is ready meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module xoshiro256ss_ranged_random_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [xrr_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [xrr_pkg::WordW-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [xrr_pkg::FuncW-1:0]     func,
  input  wire logic [xrr_pkg::WordW-1:0]     limit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [xrr_pkg::WordW-1:0]          value,
  output logic                               div_zero
);

  localparam int unsigned W = xrr_pkg::WordW;
  localparam int unsigned H = xrr_pkg::HalfW;

  xrr_pkg::state_t state, state_next;
  xrr_pkg::ctrl_t  ctrl;

  logic [W-1:0] seed_first, seed_second;
  logic [W-1:0] gen_word [4];
  logic [W-1:0] acc, z, prod, mul_q;
  logic [1:0]   mstep, widx;
  logic         round;

  logic [W-1:0]                 raw_q, limit_q;
  logic [xrr_pkg::FuncW-1:0]    func_q;
  logic [W-1:0]                 dq, dvs, rem, mask_q;
  logic [xrr_pkg::CntW-1:0]     cnt;
  logic                         neg, zero_q;

  logic         cfg_fire, in_fire, seed_hit, out_free;
  logic [W-1:0] eff_a, eff_b;
  logic [H-1:0] op_a, op_b;
  logic [W-1:0] mul_k;
  logic [W-1:0] x5, rot7, draw;
  logic [W-1:0] n0, n1, n2, n3;
  logic         is32, is16, sgn, na, nb;
  logic [W-1:0] mask, rnd, lim, ma, mb;
  logic [W:0]   trial, diff;
  logic [W-1:0] fin_val;

  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_fire  = in_valid && in_ready;
  assign seed_hit = (cfg_index == xrr_pkg::RegSeedFirst) ||
                    (cfg_index == xrr_pkg::RegSeedSecond);
  assign out_free = !out_valid || out_ready;

  assign eff_a = ((seed_first == '0) && (seed_second == '0)) ? xrr_pkg::DefaultSeedA
                                                             : seed_first;
  assign eff_b = ((seed_first == '0) && (seed_second == '0)) ? xrr_pkg::DefaultSeedB
                                                             : seed_second;

  // shared multiplier operands
  assign mul_k = round ? xrr_pkg::MixMulSecond : xrr_pkg::MixMulFirst;
  assign op_a  = (mstep == 2'd1) ? z[W-1:H] : z[H-1:0];
  assign op_b  = (mstep == 2'd2) ? mul_k[W-1:H] : mul_k[H-1:0];

  // generator step
  assign x5   = gen_word[1] + {gen_word[1][W-3:0], 2'b00};
  assign rot7 = {x5[W-8:0], x5[W-1:W-7]};
  assign draw = rot7 + {rot7[W-4:0], 3'b000};
  assign n2   = gen_word[2] ^ gen_word[0];
  assign n3   = gen_word[3] ^ gen_word[1];
  assign n1   = gen_word[1] ^ n2;
  assign n0   = gen_word[0] ^ n3;

  // request preparation
  assign is32 = (func_q == xrr_pkg::FuncU32) || (func_q == xrr_pkg::FuncS32);
  assign is16 = (func_q == xrr_pkg::FuncU16) || (func_q == xrr_pkg::FuncS16);
  assign sgn  = (func_q == xrr_pkg::FuncS64) || (func_q == xrr_pkg::FuncS32) ||
                (func_q == xrr_pkg::FuncS16);
  assign mask = is16 ? {{(W-16){1'b0}}, {16{1'b1}}}
              : is32 ? {{(W-H){1'b0}}, {H{1'b1}}} : {W{1'b1}};
  assign rnd  = is16 ? {{(W-16){1'b0}}, raw_q[W-1:W-16]}
              : is32 ? {{(W-H){1'b0}}, raw_q[W-1:H]} : raw_q;
  assign lim  = limit_q & mask;
  assign na   = sgn && (is16 ? rnd[15] : is32 ? rnd[H-1] : rnd[W-1]);
  assign nb   = sgn && (is16 ? lim[15] : is32 ? lim[H-1] : lim[W-1]);
  assign ma   = na ? ((W'(0) - rnd) & mask) : rnd;
  assign mb   = nb ? ((W'(0) - lim) & mask) : lim;

  // remainder step
  assign trial = {rem, dq[W-1]};
  assign diff  = trial - {1'b0, dvs};

  assign fin_val = zero_q ? '0 : (neg ? ((W'(0) - rem) & mask_q) : rem);

  always_comb begin
    state_next = state;
    unique case (state)
      xrr_pkg::ST_START:    state_next = xrr_pkg::ST_SEED_ADD;
      xrr_pkg::ST_SEED_ADD: state_next = xrr_pkg::ST_MIX;
      xrr_pkg::ST_MIX:      state_next = xrr_pkg::ST_MUL;
      xrr_pkg::ST_MUL: begin
        if (mstep == 2'd3) begin
          state_next = round ? xrr_pkg::ST_STORE : xrr_pkg::ST_MIX;
        end
      end
      xrr_pkg::ST_STORE: begin
        state_next = (widx == 2'd3) ? xrr_pkg::ST_IDLE : xrr_pkg::ST_SEED_ADD;
      end
      xrr_pkg::ST_IDLE: begin
        if (cfg_fire && seed_hit) begin
          state_next = xrr_pkg::ST_START;
        end else if (in_fire) begin
          state_next = xrr_pkg::ST_PREP;
        end
      end
      xrr_pkg::ST_PREP: begin
        state_next = (lim == '0) ? xrr_pkg::ST_FINISH : xrr_pkg::ST_DIV;
      end
      xrr_pkg::ST_DIV: begin
        if (cnt == xrr_pkg::CntW'(W - 1)) begin
          state_next = xrr_pkg::ST_FINISH;
        end
      end
      xrr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = xrr_pkg::ST_IDLE;
        end
      end
      default: state_next = xrr_pkg::ST_START;
    endcase
  end

  always_comb begin
    ctrl.cfg_ready = 1'b0;
    ctrl.in_ready  = 1'b0;
    unique case (state)
      xrr_pkg::ST_IDLE: begin
        ctrl.cfg_ready = 1'b1;
        ctrl.in_ready  = !cfg_valid;
      end
      default: begin
        ctrl.cfg_ready = 1'b0;
        ctrl.in_ready  = 1'b0;
      end
    endcase
  end

  assign cfg_ready = ctrl.cfg_ready;
  assign in_ready  = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= xrr_pkg::ST_START;
      seed_first <= '0;
      seed_second <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire && (cfg_index == xrr_pkg::RegSeedFirst)) begin
        seed_first <= cfg_data;
      end
      if (cfg_fire && (cfg_index == xrr_pkg::RegSeedSecond)) begin
        seed_second <= cfg_data;
      end
      if ((state == xrr_pkg::ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      xrr_pkg::ST_START: begin
        acc  <= eff_a;
        widx <= 2'd0;
      end
      xrr_pkg::ST_SEED_ADD: begin
        acc   <= acc + xrr_pkg::Golden;
        z     <= acc + xrr_pkg::Golden;
        round <= 1'b0;
      end
      xrr_pkg::ST_MIX: begin
        z     <= round ? (z ^ (z >> 27)) : (z ^ (z >> 30));
        mstep <= 2'd0;
      end
      xrr_pkg::ST_MUL: begin
        mstep <= mstep + 2'd1;
        mul_q <= op_a * op_b;
        unique case (mstep)
          2'd0: prod <= prod;
          2'd1: prod <= mul_q;
          2'd2: prod <= prod + {mul_q[H-1:0], {H{1'b0}}};
          2'd3: begin
            z     <= prod + {mul_q[H-1:0], {H{1'b0}}};
            round <= 1'b1;
          end
          default: prod <= prod;
        endcase
      end
      xrr_pkg::ST_STORE: begin
        gen_word[widx] <= z ^ (z >> 31);
        widx           <= widx + 2'd1;
        if (widx == 2'd1) begin
          acc <= eff_b;
        end
      end
      xrr_pkg::ST_IDLE: begin
        if (in_fire) begin
          raw_q       <= draw;
          func_q      <= func;
          limit_q     <= limit;
          gen_word[0] <= n0;
          gen_word[1] <= n1;
          gen_word[2] <= n2 ^ {gen_word[1][W-18:0], 17'b0};
          gen_word[3] <= {n3[18:0], n3[W-1:19]};
        end
      end
      xrr_pkg::ST_PREP: begin
        dq     <= ma;
        dvs    <= mb;
        rem    <= '0;
        cnt    <= '0;
        neg    <= na;
        mask_q <= mask;
        zero_q <= (lim == '0);
      end
      xrr_pkg::ST_DIV: begin
        rem <= diff[W] ? trial[W-1:0] : diff[W-1:0];
        dq  <= {dq[W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      xrr_pkg::ST_FINISH: begin
        if (out_free) begin
          value    <= fin_val;
          div_zero <= zero_q;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for the ranged xoshiro256** generator with splitmix64 seeding.
// Predicts every draw from its own copy of the seeds and generator words, with random idling.
// Depends on xrr_pkg and xoshiro256ss_ranged_random_top.
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit = 400000;
  localparam int HoldAt = 150;
  localparam int HoldCycles = 2000;
  localparam int TailCycles = 100;
  localparam logic [xrr_pkg::CfgIdxW-1:0] RegUnusedA = 2'd2;
  localparam logic [xrr_pkg::CfgIdxW-1:0] RegUnusedB = 2'd3;
  localparam logic [xrr_pkg::FuncW-1:0] FuncSpareA = 3'd6;
  localparam logic [xrr_pkg::FuncW-1:0] FuncSpareB = 3'd7;

  typedef struct packed {
    logic [xrr_pkg::WordW-1:0] value;
    logic                      div_zero;
  } draw_t;

  typedef struct packed {
    logic                        is_seed;
    logic [xrr_pkg::CfgIdxW-1:0] idx;
    logic [xrr_pkg::WordW-1:0]   data;
    logic [xrr_pkg::FuncW-1:0]   fn;
    logic [xrr_pkg::WordW-1:0]   lim;
    logic [3:0]                  gap;
  } req_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [xrr_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [xrr_pkg::WordW-1:0]   cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [xrr_pkg::FuncW-1:0]   func = '0;
  logic [xrr_pkg::WordW-1:0]   limit = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [xrr_pkg::WordW-1:0]   value;
  logic                        div_zero;

  req_t  draw_reqs[$];
  draw_t due_draws[$];

  logic [xrr_pkg::WordW-1:0] seed_a;
  logic [xrr_pkg::WordW-1:0] seed_b;
  logic [xrr_pkg::WordW-1:0] gw [4];

  int n_taken = 0;
  int n_results = 0;
  int n_fail = 0;
  int cycles = 0;
  int tx_sent = 0;
  int tx_gap = 0;
  int rx_seen = 0;
  int rx_wait = 0;
  bit rx_armed = 1'b1;

  xoshiro256ss_ranged_random_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .limit(limit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value(value),
    .div_zero(div_zero)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [xrr_pkg::WordW-1:0] mix64(logic [xrr_pkg::WordW-1:0] x);
    logic [xrr_pkg::WordW-1:0] z;
    z = (x ^ (x >> 30)) * xrr_pkg::MixMulFirst;
    z = (z ^ (z >> 27)) * xrr_pkg::MixMulSecond;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [xrr_pkg::WordW-1:0] rotl(logic [xrr_pkg::WordW-1:0] x,
                                                      int unsigned k);
    return (x << k) | (x >> (xrr_pkg::WordW - k));
  endfunction

  function automatic void reseed_words();
    logic [xrr_pkg::WordW-1:0] a;
    logic [xrr_pkg::WordW-1:0] b;
    a = seed_a;
    b = seed_b;
    if (a == '0 && b == '0) begin
      a = xrr_pkg::DefaultSeedA;
      b = xrr_pkg::DefaultSeedB;
    end
    gw[0] = mix64(a + xrr_pkg::Golden);
    gw[1] = mix64(a + xrr_pkg::Golden + xrr_pkg::Golden);
    gw[2] = mix64(b + xrr_pkg::Golden);
    gw[3] = mix64(b + xrr_pkg::Golden + xrr_pkg::Golden);
  endfunction

  function automatic void write_seed(logic [xrr_pkg::CfgIdxW-1:0] idx,
                                     logic [xrr_pkg::WordW-1:0] data);
    if (idx == xrr_pkg::RegSeedFirst) begin
      seed_a = data;
    end else if (idx == xrr_pkg::RegSeedSecond) begin
      seed_b = data;
    end else begin
      return;
    end
    reseed_words();
  endfunction

  function automatic logic [xrr_pkg::WordW-1:0] step_generator();
    logic [xrr_pkg::WordW-1:0] res;
    logic [xrr_pkg::WordW-1:0] t;
    res = rotl(gw[1] * 64'd5, 7) * 64'd9;
    t = gw[1] << 17;
    gw[2] = gw[2] ^ gw[0];
    gw[3] = gw[3] ^ gw[1];
    gw[1] = gw[1] ^ gw[2];
    gw[0] = gw[0] ^ gw[3];
    gw[2] = gw[2] ^ t;
    gw[3] = rotl(gw[3], 45);
    return res;
  endfunction

  function automatic draw_t predict_draw(logic [xrr_pkg::FuncW-1:0] fn,
                                         logic [xrr_pkg::WordW-1:0] lim_in,
                                         logic [xrr_pkg::WordW-1:0] raw);
    draw_t d;
    int unsigned shift;
    logic sgn;
    logic neg;
    logic [xrr_pkg::WordW-1:0] mask;
    logic [xrr_pkg::WordW-1:0] rnd;
    logic [xrr_pkg::WordW-1:0] lim;
    logic [xrr_pkg::WordW-1:0] sbit;
    logic [xrr_pkg::WordW-1:0] ma;
    logic [xrr_pkg::WordW-1:0] mb;
    logic [xrr_pkg::WordW-1:0] r;
    shift = 0;
    sgn = 1'b0;
    case (fn)
      xrr_pkg::FuncU32: shift = 32;
      xrr_pkg::FuncU16: shift = 48;
      xrr_pkg::FuncS64: sgn = 1'b1;
      xrr_pkg::FuncS32: begin
        shift = 32;
        sgn = 1'b1;
      end
      xrr_pkg::FuncS16: begin
        shift = 48;
        sgn = 1'b1;
      end
      default: shift = 0;
    endcase
    mask = {xrr_pkg::WordW{1'b1}} >> shift;
    rnd = raw >> shift;
    lim = lim_in & mask;
    d.value = '0;
    d.div_zero = 1'b0;
    if (lim == '0) begin
      d.div_zero = 1'b1;
    end else if (sgn) begin
      sbit = (mask >> 1) + 64'd1;
      neg = (rnd & sbit) != '0;
      ma = neg ? ((64'd0 - rnd) & mask) : (rnd & mask);
      mb = ((lim & sbit) != '0) ? ((64'd0 - lim) & mask) : lim;
      r = ma % mb;
      d.value = neg ? ((64'd0 - r) & mask) : r;
    end else begin
      d.value = rnd % lim;
    end
    return d;
  endfunction

  function automatic logic [xrr_pkg::WordW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [xrr_pkg::WordW-1:0] pick_limit();
    logic [xrr_pkg::WordW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = rand64();
      1: v = 64'($urandom_range(1, 20));
      2: v = 64'd0 - 64'($urandom_range(1, 20));
      3: v = '0;
      4: v = rand64() & 64'hFFFF_FFFF_FFFF_0000;
      5: v = rand64() & 64'hFFFF_FFFF_0000_0000;
      6: v = {rand64()} ^ {48'd0, 16'($urandom)};
      default: v = 64'd1 << $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  task automatic push_draw(logic [xrr_pkg::FuncW-1:0] fn, logic [xrr_pkg::WordW-1:0] lim,
                           int gap);
    req_t r;
    r = '0;
    r.fn = fn;
    r.lim = lim;
    r.gap = 4'(gap);
    draw_reqs.push_back(r);
  endtask

  task automatic push_seed(logic [xrr_pkg::CfgIdxW-1:0] idx, logic [xrr_pkg::WordW-1:0] data);
    req_t r;
    r = '0;
    r.is_seed = 1'b1;
    r.idx = idx;
    r.data = data;
    r.gap = 4'($urandom_range(0, 11));
    draw_reqs.push_back(r);
  endtask

  task automatic add_random(int n);
    logic [xrr_pkg::FuncW-1:0] fn;
    bit calm;
    for (int i = 0; i < n; i++) begin
      calm = ((i / 40) % 3) == 2;
      if ($urandom_range(0, 15) == 0) fn = xrr_pkg::FuncW'($urandom_range(6, 7));
      else fn = xrr_pkg::FuncW'($urandom_range(0, 5));
      push_draw(fn, pick_limit(), calm ? 0 : $urandom_range(0, 11));
    end
  endtask

  // request driver: one request offered at a time, seed writes only once every draw is back
  always @(negedge clk) begin : drive
    logic iv;
    logic cv;
    req_t nxt;
    if (!rst) begin
      iv = in_valid;
      cv = cfg_valid;
      if ((iv || cv) && n_taken == tx_sent) begin
        iv = 1'b0;
        cv = 1'b0;
      end
      if (!iv && !cv) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
        end else if (draw_reqs.size() > 0) begin
          if (!draw_reqs[0].is_seed || due_draws.size() == 0) begin
            nxt = draw_reqs.pop_front();
            tx_sent = tx_sent + 1;
            tx_gap = nxt.gap;
            if (nxt.is_seed) begin
              cfg_index <= nxt.idx;
              cfg_data <= nxt.data;
              cv = 1'b1;
            end else begin
              func <= nxt.fn;
              limit <= nxt.lim;
              iv = 1'b1;
            end
          end
        end
      end
      in_valid <= iv;
      cfg_valid <= cv;
    end
  end

  // result receiver: may stall on each fresh result, once for a long stretch
  always @(negedge clk) begin
    if (!rst) begin
      if (rx_seen != n_results) begin
        rx_seen = n_results;
        rx_armed = 1'b1;
      end
      if (rx_armed && out_valid) begin
        rx_armed = 1'b0;
        if (n_results == HoldAt) rx_wait = HoldCycles;
        else if (((n_results / 64) % 3) == 1) rx_wait = 0;
        else rx_wait = $urandom_range(0, 11);
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait = rx_wait - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin : watch
    draw_t want;
    cycles = cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        write_seed(cfg_index, cfg_data);
        n_taken <= n_taken + 1;
      end
      if (in_valid && in_ready) begin
        due_draws.push_back(predict_draw(func, limit, step_generator()));
        n_taken <= n_taken + 1;
      end
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (due_draws.size() == 0) begin
          $error("unexpected result: value %h div_zero %b", value, div_zero);
          n_fail = n_fail + 1;
        end else begin
          want = due_draws.pop_front();
          if (value !== want.value) begin
            $error("value: expected %h, got %h", want.value, value);
            n_fail = n_fail + 1;
          end
          if (div_zero !== want.div_zero) begin
            $error("div_zero: expected %b, got %b", want.div_zero, div_zero);
            n_fail = n_fail + 1;
          end
        end
      end
    end
  end

  initial begin
    seed_a = '0;
    seed_b = '0;
    reseed_words();

    push_draw(xrr_pkg::FuncU64, 64'd0, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncU32, 64'd0, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncU16, 64'd0, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS64, 64'd0, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS32, 64'd0, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS16, 64'd0, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncU32, 64'hFFFF_FFFF_0000_0000, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS16, 64'hFFFF_FFFF_FFFF_0000, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncU64, '1, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncU64, 64'd1, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncU32, 64'h0000_0000_FFFF_FFFF, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncU16, 64'h0000_0000_0000_FFFF, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS64, '1, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS32, 64'h0000_0000_FFFF_FFFF, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS16, 64'h0000_0000_0000_FFFF, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS64, 64'h8000_0000_0000_0000, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS32, 64'h0000_0000_8000_0000, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS16, 64'h0000_0000_0000_8000, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS64, 64'h7FFF_FFFF_FFFF_FFFF, $urandom_range(0, 11));
    push_draw(xrr_pkg::FuncS16, 64'h0000_0000_0000_7FFF, $urandom_range(0, 11));
    push_draw(FuncSpareA, 64'd12345, $urandom_range(0, 11));
    push_draw(FuncSpareB, 64'd0, $urandom_range(0, 11));
    push_draw(FuncSpareA, '1, $urandom_range(0, 11));

    push_seed(xrr_pkg::RegSeedFirst, rand64());
    push_seed(xrr_pkg::RegSeedSecond, rand64());
    add_random(100);
    push_seed(xrr_pkg::RegSeedFirst, '1);
    push_seed(xrr_pkg::RegSeedSecond, '0);
    add_random(100);
    push_seed(xrr_pkg::RegSeedFirst, '0);
    add_random(100);
    push_seed(xrr_pkg::RegSeedSecond, '1);
    push_seed(RegUnusedA, rand64());
    push_seed(RegUnusedB, rand64());
    add_random(100);
    push_seed(xrr_pkg::RegSeedFirst, rand64());
    push_seed(xrr_pkg::RegSeedSecond, rand64());
    add_random(200);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (draw_reqs.size() > 0 || in_valid || cfg_valid) @(posedge clk);
    while (due_draws.size() > 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (n_fail == 0 && due_draws.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
